[sv/upx_pkg.sv]
// Shared types and constants for the pixel-art 2x upscaler.
// Used by the block expander, the top level, the checker and the testbench.
// No dependencies.
package upx_pkg;

  localparam int PIX_W = 24;
  typedef logic [PIX_W-1:0] pix_t;

  // channel masks for the per-channel truncating average
  localparam pix_t RB_MASK = 24'hFF00FF;
  localparam pix_t G_MASK  = 24'h00FF00;

  // configuration register file
  localparam int FRAME_W_BITS = 11;
  localparam int FRAME_H_BITS = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 11'd640;
  localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET = 13'd400;

  // input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  // which neighbours of a block lie inside the frame
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } upx_bound_t;

  // one line store entry: row above and middle row of a column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_word_t;

endpackage

[sv/upx_line_store.sv]
// Dual-read, single-write line store with registered read data.
// A read that hits the entry written at the same edge returns the new data.
// No package dependencies.
module upx_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DW-1:0]            rdata_a,
  output logic [DW-1:0]            rdata_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_a;
  logic [DW-1:0] rd_b;
  logic [DW-1:0] fwd;
  logic          hit_a;
  logic          hit_b;

  // write, read both ports, note same-entry collisions
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a  <= mem[raddr_a];
    rd_b  <= mem[raddr_b];
    hit_a <= we && (waddr == raddr_a);
    hit_b <= we && (waddr == raddr_b);
    fwd   <= wdata;
  end

  // forward the colliding write over the stale read
  assign rdata_a = hit_a ? fwd : rd_a;
  assign rdata_b = hit_b ? fwd : rd_b;

endmodule

[sv/upx_expand.sv]
// Expands one 3x3 neighbourhood into a 2x2 block: Scale2x edge rules,
// then a diagonal average where a rule keeps the centre. Uses upx_pkg.
module upx_expand (
  input  upx_pkg::pix_t [8:0]  nb,
  input  upx_pkg::upx_bound_t  bounds,
  output upx_pkg::pix_t        q_tl,
  output upx_pkg::pix_t        q_tr,
  output upx_pkg::pix_t        q_bl,
  output upx_pkg::pix_t        q_br
);
  import upx_pkg::*;

  // per-channel truncating average of two pixels
  function automatic pix_t avg2(input pix_t x, input pix_t y);
    logic [PIX_W:0] rb;
    logic [PIX_W:0] g;
    rb = {1'b0, x & RB_MASK} + {1'b0, y & RB_MASK};
    g  = {1'b0, x & G_MASK} + {1'b0, y & G_MASK};
    return (rb[PIX_W:1] & RB_MASK) | (g[PIX_W:1] & G_MASK);
  endfunction

  pix_t p, a, b, c, d, e, f, g, h;
  pix_t p0, p1, p2, p3;

  // replicate the centre for neighbours outside the frame
  always_comb begin
    p = nb[4];
    a = bounds.up ? nb[1] : p;
    c = bounds.lf ? nb[3] : p;
    b = bounds.rt ? nb[5] : p;
    d = bounds.dn ? nb[7] : p;
    e = (bounds.up && bounds.lf) ? nb[0] : p;
    f = (bounds.up && bounds.rt) ? nb[2] : p;
    g = (bounds.dn && bounds.lf) ? nb[6] : p;
    h = (bounds.dn && bounds.rt) ? nb[8] : p;
  end

  // edge rules, then blend with the diagonal on a staircase
  always_comb begin
    p0 = (c == a && c != d && a != b) ? a : p;
    p1 = (a == b && a != c && b != d) ? b : p;
    p2 = (d == c && d != b && c != a) ? c : p;
    p3 = (b == d && b != a && d != c) ? d : p;
    if (p0 == p && e == a && e == c && a != b && c != d) begin
      p0 = avg2(p, e);
    end
    if (p1 == p && f == a && f == b && a != c && b != d) begin
      p1 = avg2(p, f);
    end
    if (p2 == p && g == c && g == d && c != a && d != b) begin
      p2 = avg2(p, g);
    end
    if (p3 == p && h == b && h == d && b != a && d != c) begin
      p3 = avg2(p, h);
    end
  end

  assign q_tl = p0;
  assign q_tr = p1;
  assign q_bl = p2;
  assign q_br = p3;

endmodule

[sv/pixel_art_2x_upscaler_unit.sv]
// Top level of the pixel-art 2x upscaler: control, line store, window,
// two block expanders and the result queue. Uses upx_pkg, upx_line_store,
// upx_expand.
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       kind, pixel
//   out       out_valid / out_ready     src_column, src_row, top_left, top_right,
//                                       bottom_left, bottom_right, last_of_run,
//                                       frame_done
//   cfg       cfg_write                 cfg_index, cfg_data
//
// One input word per cycle while in_ready is high. A row-end pixel below the
// first row gives up to two results in the same cycle; the eight-entry result
// queue absorbs them and in_ready drops only when the queue plus the words in
// flight could overflow it. A result passes the stage 1 and stage 2 registers
// before it is written into the queue and shows on the output. The registered
// line store read sets the pipeline depth. Reset is synchronous and clears
// control state only; the line store needs no clearing pass.
module pixel_art_2x_upscaler_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  upx_pkg::pix_t                         pixel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]          src_column,
  output logic [$clog2(MAX_HEIGHT)-1:0]         src_row,
  output upx_pkg::pix_t                         top_left,
  output upx_pkg::pix_t                         top_right,
  output upx_pkg::pix_t                         bottom_left,
  output upx_pkg::pix_t                         bottom_right,
  output logic                                  last_of_run,
  output logic                                  frame_done,
  input  logic                                  cfg_write,
  input  logic [upx_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [upx_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import upx_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CXW   = CW + 1;
  localparam int RXW   = RW + 1;
  localparam int FWW   = (CXW > FRAME_W_BITS) ? CXW : FRAME_W_BITS;
  localparam int FHW   = (RXW > FRAME_H_BITS) ? RXW : FRAME_H_BITS;
  localparam int RSV_W = OUT_CNT_W + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [FRAME_W_BITS-1:0] frame_width;
  logic [FRAME_H_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_W_RESET;
      frame_height <= FRAME_H_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_W_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp the frame size to 1..MAX
  logic [FWW-1:0] fw_ext;
  logic [FHW-1:0] fh_ext;
  logic [CXW-1:0] eff_w;
  logic [RXW-1:0] eff_h;

  assign fw_ext = FWW'(frame_width);
  assign fh_ext = FHW'(frame_height);

  always_comb begin
    if (frame_width == '0) begin
      eff_w = CXW'(1);
    end else if (fw_ext > FWW'(MAX_WIDTH)) begin
      eff_w = CXW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext[CXW-1:0];
    end
    if (frame_height == '0) begin
      eff_h = RXW'(1);
    end else if (fh_ext > FHW'(MAX_HEIGHT)) begin
      eff_h = RXW'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext[RXW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Position state and accept stage
  // ---------------------------------------------------------------------
  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [CW-1:0] pending_column;
  logic [RW-1:0] pending_row;
  logic          draining;

  logic           accept;
  logic           take_pix;
  logic           take_drain;
  logic [CXW-1:0] cx;
  logic [RXW-1:0] rx;
  logic [CXW-1:0] pcx;
  logic           row_end;
  logic           frame_end;
  logic           drain_rt;
  logic           pix_ea;
  logic           pix_eb;
  logic [CW-1:0]  raddr_a;
  logic [CW-1:0]  raddr_b;

  assign accept     = in_valid && in_ready;
  assign take_pix   = accept && (kind == KIND_PIXEL) && !draining;
  assign take_drain = accept && (kind == KIND_DRAIN) && draining;

  assign cx        = CXW'(in_column);
  assign rx        = RXW'(in_row);
  assign pcx       = CXW'(pending_column);
  assign row_end   = (cx + CXW'(1)) >= eff_w;
  assign frame_end = (rx + RXW'(1)) >= eff_h;
  assign drain_rt  = (pcx + CXW'(1)) < eff_w;
  assign pix_ea    = (in_row != '0) && (in_column != '0);
  assign pix_eb    = (in_row != '0) && row_end;

  // port a: the pixel's column, or the drain block's centre column
  // port b: the column right of the drain block, held at the last entry
  always_comb begin
    logic [CXW-1:0] nxt;
    nxt     = pcx + CXW'(1);
    raddr_a = draining ? pending_column : in_column;
    if (nxt >= CXW'(MAX_WIDTH)) begin
      raddr_b = pending_column;
    end else begin
      raddr_b = nxt[CW-1:0];
    end
  end

  // advance the input and pending positions
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column      <= '0;
      in_row         <= '0;
      pending_column <= '0;
      pending_row    <= '0;
      draining       <= 1'b0;
    end else if (take_pix) begin
      if (row_end) begin
        in_column      <= '0;
        pending_row    <= in_row;
        pending_column <= '0;
        if (frame_end) begin
          in_row   <= '0;
          draining <= 1'b1;
        end else begin
          in_row <= in_row + RW'(1);
        end
      end else begin
        in_column <= in_column + CW'(1);
        if (in_row != '0) begin
          pending_row    <= in_row - RW'(1);
          pending_column <= in_column;
        end
      end
    end else if (take_drain) begin
      if (drain_rt) begin
        pending_column <= pending_column + CW'(1);
      end else begin
        draining       <= 1'b0;
        pending_column <= '0;
        pending_row    <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read returns; update window and line store
  // ---------------------------------------------------------------------
  logic          s1_pix;
  logic          s1_drain;
  logic          s1_ea;
  logic          s1_eb;
  pix_t          s1_px;
  logic [CW-1:0] s1_addr;
  upx_bound_t    s1_bnd_a;
  upx_bound_t    s1_bnd_b;
  logic [CW-1:0] s1_col_a;
  logic [CW-1:0] s1_col_b;
  logic [RW-1:0] s1_row;
  logic          s1_last_a;
  logic          s1_done_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_pix   <= 1'b0;
      s1_drain <= 1'b0;
      s1_ea    <= 1'b0;
      s1_eb    <= 1'b0;
    end else begin
      s1_pix   <= take_pix;
      s1_drain <= take_drain;
      s1_ea    <= (take_pix && pix_ea) || take_drain;
      s1_eb    <= take_pix && pix_eb;
    end
  end

  // capture the block descriptions of the accepted word
  always_ff @(posedge clk) begin
    s1_px   <= pixel;
    s1_addr <= in_column;
    if (draining) begin
      s1_bnd_a  <= '{up: pending_row != '0, dn: 1'b0,
                     lf: pending_column != '0, rt: drain_rt};
      s1_col_a  <= pending_column;
      s1_row    <= pending_row;
      s1_last_a <= 1'b1;
      s1_done_a <= !drain_rt;
    end else begin
      s1_bnd_a  <= '{up: rx >= RXW'(2), dn: 1'b1,
                     lf: cx >= CXW'(2), rt: cx < eff_w};
      s1_col_a  <= in_column - CW'(1);
      s1_row    <= in_row - RW'(1);
      s1_last_a <= !pix_eb;
      s1_done_a <= 1'b0;
    end
    s1_bnd_b <= '{up: rx >= RXW'(2), dn: 1'b1, lf: in_column != '0, rt: 1'b0};
    s1_col_b <= in_column;
  end

  line_word_t rd_a;
  line_word_t rd_b;
  line_word_t wr_word;

  // move the middle line up and store the new pixel as middle
  assign wr_word = '{upper: rd_a.middle, middle: s1_px};

  upx_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    ($bits(line_word_t))
  ) u_lines (
    .clk     (clk),
    .we      (s1_pix),
    .waddr   (s1_addr),
    .wdata   (wr_word),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  pix_t [8:0]       win;
  pix_t [8:0]       win_next;
  line_word_t [2:0] dcol;

  // shift the window left and bring in the new column
  always_comb begin
    for (int k = 0; k < 9; k += 3) begin
      win_next[k]     = win[k + 1];
      win_next[k + 1] = win[k + 2];
    end
    win_next[2] = rd_a.upper;
    win_next[5] = rd_a.middle;
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (s1_pix) begin
      win <= win_next;
    end
    if (s1_drain) begin
      dcol[0] <= dcol[1];
      dcol[1] <= rd_a;
      dcol[2] <= rd_b;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: expand blocks and push into the result queue
  // ---------------------------------------------------------------------
  logic          s2_drain;
  logic          s2_ea;
  logic          s2_eb;
  upx_bound_t    s2_bnd_a;
  upx_bound_t    s2_bnd_b;
  logic [CW-1:0] s2_col_a;
  logic [CW-1:0] s2_col_b;
  logic [RW-1:0] s2_row;
  logic          s2_last_a;
  logic          s2_done_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_drain <= 1'b0;
      s2_ea    <= 1'b0;
      s2_eb    <= 1'b0;
    end else begin
      s2_drain <= s1_drain;
      s2_ea    <= s1_ea;
      s2_eb    <= s1_eb;
    end
  end

  always_ff @(posedge clk) begin
    s2_bnd_a  <= s1_bnd_a;
    s2_bnd_b  <= s1_bnd_b;
    s2_col_a  <= s1_col_a;
    s2_col_b  <= s1_col_b;
    s2_row    <= s1_row;
    s2_last_a <= s1_last_a;
    s2_done_a <= s1_done_a;
  end

  pix_t [8:0] nb_a;
  pix_t [8:0] nb_b;

  // drain blocks have no row below; the row-end block has no right column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s2_drain) begin
        nb_a[k]     = dcol[k].upper;
        nb_a[3 + k] = dcol[k].middle;
        nb_a[6 + k] = '0;
      end else begin
        nb_a[k]     = win[k];
        nb_a[3 + k] = win[3 + k];
        nb_a[6 + k] = win[6 + k];
      end
    end
    for (int k = 0; k < 9; k += 3) begin
      nb_b[k]     = win[k + 1];
      nb_b[k + 1] = win[k + 2];
      nb_b[k + 2] = '0;
    end
  end

  pix_t a_tl, a_tr, a_bl, a_br;
  pix_t b_tl, b_tr, b_bl, b_br;

  upx_expand u_expand_a (
    .nb     (nb_a),
    .bounds (s2_bnd_a),
    .q_tl   (a_tl),
    .q_tr   (a_tr),
    .q_bl   (a_bl),
    .q_br   (a_br)
  );

  upx_expand u_expand_b (
    .nb     (nb_b),
    .bounds (s2_bnd_b),
    .q_tl   (b_tl),
    .q_tr   (b_tr),
    .q_bl   (b_bl),
    .q_br   (b_br)
  );

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  logic [CW-1:0]        q_col  [OUT_DEPTH];
  logic [RW-1:0]        q_row  [OUT_DEPTH];
  pix_t                 q_tl   [OUT_DEPTH];
  pix_t                 q_tr   [OUT_DEPTH];
  pix_t                 q_bl   [OUT_DEPTH];
  pix_t                 q_br   [OUT_DEPTH];
  logic                 q_last [OUT_DEPTH];
  logic                 q_done [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] head;
  logic [OUT_PTR_W-1:0] tail;
  logic [OUT_PTR_W-1:0] tail_b;
  logic [OUT_CNT_W-1:0] out_count;
  logic [1:0]           n1;
  logic [1:0]           n2;
  logic                 pop;
  logic [RSV_W-1:0]     reserve;

  assign n1     = {1'b0, s1_ea} + {1'b0, s1_eb};
  assign n2     = {1'b0, s2_ea} + {1'b0, s2_eb};
  assign tail_b = tail + OUT_PTR_W'(s2_ea);
  assign pop    = out_valid && out_ready;

  // hold room for every result still in flight plus two for a new word
  assign reserve  = RSV_W'(out_count) + RSV_W'(n1) + RSV_W'(n2);
  assign in_ready = !rst && (reserve <= RSV_W'(OUT_DEPTH - 2));

  // write block a at the tail, block b right after it
  always_ff @(posedge clk) begin
    if (s2_ea) begin
      q_col[tail]  <= s2_col_a;
      q_row[tail]  <= s2_row;
      q_tl[tail]   <= a_tl;
      q_tr[tail]   <= a_tr;
      q_bl[tail]   <= a_bl;
      q_br[tail]   <= a_br;
      q_last[tail] <= s2_last_a;
      q_done[tail] <= s2_done_a;
    end
    if (s2_eb) begin
      q_col[tail_b]  <= s2_col_b;
      q_row[tail_b]  <= s2_row;
      q_tl[tail_b]   <= b_tl;
      q_tr[tail_b]   <= b_tr;
      q_bl[tail_b]   <= b_bl;
      q_br[tail_b]   <= b_br;
      q_last[tail_b] <= 1'b1;
      q_done[tail_b] <= 1'b0;
    end
  end

  // advance pointers and the word count
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      out_count <= '0;
    end else begin
      tail      <= tail + OUT_PTR_W'(n2);
      head      <= head + OUT_PTR_W'(pop);
      out_count <= out_count + OUT_CNT_W'(n2) - OUT_CNT_W'(pop);
    end
  end

  assign out_valid    = (out_count != '0);
  assign src_column   = q_col[head];
  assign src_row      = q_row[head];
  assign top_left     = q_tl[head];
  assign top_right    = q_tr[head];
  assign bottom_left  = q_bl[head];
  assign bottom_right = q_br[head];
  assign last_of_run  = q_last[head];
  assign frame_done   = q_done[head];

endmodule

[sv/upx_checker.sv]
// Port-level checks for pixel_art_2x_upscaler_unit, bound to the top level.
// Depends on upx_pkg for the pixel type.
module upx_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [$clog2(MAX_WIDTH)-1:0]  src_column,
  input logic [$clog2(MAX_HEIGHT)-1:0] src_row,
  input upx_pkg::pix_t                 top_left,
  input upx_pkg::pix_t                 bottom_right,
  input logic                          last_of_run,
  input logic                          frame_done
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_column) && $stable(src_row)
      && $stable(top_left) && $stable(bottom_right) && $stable(last_of_run))
    else $error("result word changed while stalled");

  // the frame's final block closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // the first block of a row-end pair is followed at once by its right neighbour
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      out_valid && (src_column == $past(src_column) + 1'b1)
      && (src_row == $past(src_row)))
    else $error("row-end pair broken");

  // reset empties the result queue
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind pixel_art_2x_upscaler_unit upx_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_upx_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .src_column   (src_column),
  .src_row      (src_row),
  .top_left     (top_left),
  .bottom_right (bottom_right),
  .last_of_run  (last_of_run),
  .frame_done   (frame_done)
);

[tb/sv/pixel_art_2x_upscaler_unit_test.sv]
// Testbench for pixel_art_2x_upscaler_unit: predicts every 2x2 block from the
// accepted words and checks the result stream in order. Depends on upx_pkg
// and the upscaler top level with its submodules.
module pixel_art_2x_upscaler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upx_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int COL_W = $clog2(MAX_W);
  localparam int ROW_W = $clog2(MAX_H);
  localparam int SETTLE_CYCLES = 8;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int RANDOM_WORDS = 400;
  localparam longint TIMEOUT_NS = 80_000_000;

  // 3x3 neighborhood, row-major, centre at index 4
  typedef logic [8:0][PIX_W-1:0] nbhd_t;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pix_t             tl;
    pix_t             tr;
    pix_t             bl;
    pix_t             br;
    logic             last;
    logic             done;
  } block_t;

  // Predicts the block stream and checks it against the observed results
  class upscale_scoreboard;
    pix_t row_above [MAX_W];
    pix_t row_mid [MAX_W];
    nbhd_t win;
    int unsigned col_in, row_in, emit_col, emit_row;
    bit flushing;
    logic [FRAME_W_BITS-1:0] cfg_w;
    logic [FRAME_H_BITS-1:0] cfg_h;
    block_t blocks_due [$];
    int unsigned errors;

    function new();
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_mid[i] = '0;
      end
      win = '0;
      col_in = 0;
      row_in = 0;
      emit_col = 0;
      emit_row = 0;
      flushing = 1'b0;
      cfg_w = FRAME_W_RESET;
      cfg_h = FRAME_H_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: cfg_w = data[FRAME_W_BITS-1:0];
        REG_FRAME_HEIGHT: cfg_h = data[FRAME_H_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_width();
      if (cfg_w == 0) return 1;
      return (cfg_w > MAX_W) ? MAX_W : cfg_w;
    endfunction

    function int unsigned active_height();
      if (cfg_h == 0) return 1;
      return (cfg_h > MAX_H) ? MAX_H : cfg_h;
    endfunction

    function int unsigned pending();
      return blocks_due.size();
    endfunction

    function int unsigned line_slot(int unsigned col);
      return (col < MAX_W) ? col : MAX_W - 1;
    endfunction

    // per-channel truncating average; 25 bits keep the red carry
    function pix_t channel_mean(pix_t x, pix_t y);
      logic [PIX_W:0] rb, gg;
      rb = ({1'b0, x & RB_MASK} + {1'b0, y & RB_MASK}) >> 1;
      gg = ({1'b0, x & G_MASK} + {1'b0, y & G_MASK}) >> 1;
      return (rb[PIX_W-1:0] & RB_MASK) | (gg[PIX_W-1:0] & G_MASK);
    endfunction

    // edge rules first, then the diagonal blend where a corner kept the centre
    function block_t scale_block(nbhd_t n, bit up, bit dn, bit lf, bit rt);
      pix_t p, a, b, c, d, e, f, g, h;
      block_t blk;
      p = n[4];
      a = up ? n[1] : p;
      c = lf ? n[3] : p;
      b = rt ? n[5] : p;
      d = dn ? n[7] : p;
      e = (up && lf) ? n[0] : p;
      f = (up && rt) ? n[2] : p;
      g = (dn && lf) ? n[6] : p;
      h = (dn && rt) ? n[8] : p;
      blk.tl = (c == a && c != d && a != b) ? a : p;
      blk.tr = (a == b && a != c && b != d) ? b : p;
      blk.bl = (d == c && d != b && c != a) ? c : p;
      blk.br = (b == d && b != a && d != c) ? d : p;
      if (blk.tl == p && e == a && e == c && a != b && c != d) blk.tl = channel_mean(p, e);
      if (blk.tr == p && f == a && f == b && a != c && b != d) blk.tr = channel_mean(p, f);
      if (blk.bl == p && g == c && g == d && c != a && d != b) blk.bl = channel_mean(p, g);
      if (blk.br == p && h == b && h == d && b != a && d != c) blk.br = channel_mean(p, h);
      return blk;
    endfunction

    // advance the model by one accepted word and queue the blocks it causes
    function void note_word(logic k, pix_t px);
      int unsigned w, h, c, r, ix, col, d;
      bit row_end;
      nbhd_t n;
      block_t blk;
      w = active_width();
      h = active_height();
      if (k == KIND_DRAIN) begin
        // drain tick: emit the next block of the last row, ignore when idle
        if (!flushing) return;
        for (d = 0; d < 3; d++) begin
          col = emit_col + d;
          ix = line_slot(col >= 1 ? col - 1 : 0);
          n[d] = row_above[ix];
          n[3 + d] = row_mid[ix];
          n[6 + d] = '0;
        end
        blk = scale_block(n, emit_row > 0, 1'b0, emit_col > 0, emit_col + 1 < w);
        blk.col = COL_W'(emit_col);
        blk.row = ROW_W'(emit_row);
        blk.last = 1'b1;
        blk.done = !(emit_col + 1 < w);
        if (blk.done) begin
          flushing = 1'b0;
          emit_col = 0;
          emit_row = 0;
        end else begin
          emit_col = emit_col + 1;
        end
        blocks_due.push_back(blk);
        return;
      end
      // pixels are dropped while the last row drains
      if (flushing) return;
      c = col_in;
      r = row_in;
      ix = line_slot(c);
      for (d = 0; d < 3; d++) begin
        win[3 * d] = win[3 * d + 1];
        win[3 * d + 1] = win[3 * d + 2];
      end
      win[2] = row_above[ix];
      win[5] = row_mid[ix];
      win[8] = px;
      row_above[ix] = row_mid[ix];
      row_mid[ix] = px;
      row_end = (c + 1 >= w);
      if (r >= 1) begin
        if (c >= 1) begin
          blk = scale_block(win, r >= 2, 1'b1, c >= 2, c < w);
          blk.col = COL_W'(c - 1);
          blk.row = ROW_W'(r - 1);
          blk.last = !row_end;
          blk.done = 1'b0;
          blocks_due.push_back(blk);
        end
        // row end completes the last centre as well, right column outside
        if (row_end) begin
          for (d = 0; d < 3; d++) begin
            n[3 * d] = win[3 * d + 1];
            n[3 * d + 1] = win[3 * d + 2];
            n[3 * d + 2] = '0;
          end
          blk = scale_block(n, r >= 2, 1'b1, c >= 1, 1'b0);
          blk.col = COL_W'(c);
          blk.row = ROW_W'(r - 1);
          blk.last = 1'b1;
          blk.done = 1'b0;
          blocks_due.push_back(blk);
        end
      end
      if (row_end) begin
        col_in = 0;
        emit_row = r;
        emit_col = 0;
        if (r + 1 >= h) begin
          row_in = 0;
          flushing = 1'b1;
        end else begin
          row_in = r + 1;
        end
      end else begin
        col_in = c + 1;
        if (r >= 1) begin
          emit_row = r - 1;
          emit_col = c;
        end
      end
    endfunction

    function void match_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // compare one result with the oldest expected block
    function void check_block(block_t got);
      block_t want;
      if (blocks_due.size() == 0) begin
        errors++;
        $display("%0t: expected no block actual col %0d row %0d", $time, got.col, got.row);
        return;
      end
      want = blocks_due.pop_front();
      match_field("src_column", PIX_W'(want.col), PIX_W'(got.col));
      match_field("src_row", PIX_W'(want.row), PIX_W'(got.row));
      match_field("top_left", want.tl, got.tl);
      match_field("top_right", want.tr, got.tr);
      match_field("bottom_left", want.bl, got.bl);
      match_field("bottom_right", want.br, got.br);
      match_field("last_of_run", PIX_W'(want.last), PIX_W'(got.last));
      match_field("frame_done", PIX_W'(want.done), PIX_W'(got.done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic kind;
  pix_t pixel;
  logic out_valid;
  logic out_ready;
  logic [COL_W-1:0] src_column;
  logic [ROW_W-1:0] src_row;
  pix_t top_left;
  pix_t top_right;
  pix_t bottom_left;
  pix_t bottom_right;
  logic last_of_run;
  logic frame_done;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  upscale_scoreboard sb;
  int unsigned words_sent = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  bit squeeze_req = 1'b0;

  // smallest frame sizes (raw register values); zero clamps to one
  int unsigned extreme_w [5] = '{0, 1, 2, 1, 3};
  int unsigned extreme_h [5] = '{0, 2, 1, 1, 1};

  pixel_art_2x_upscaler_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .src_column   (src_column),
    .src_row      (src_row),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0 selects fully random pixels, otherwise a palette of that many colors
  function automatic int unsigned pick_colors();
    if ($urandom_range(0, 99) < 15) return 0;
    return $urandom_range(2, 4);
  endfunction

  // offer one word, hold it until accepted, then maybe drop valid for a gap
  task automatic send_word(input logic k, input pix_t px);
    int unsigned gap;
    in_valid <= 1'b1;
    kind <= k;
    pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(k, px);
    words_sent++;
    gap = pick_gap(steady_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every expected block is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // width register ignores the top data bits, so fill them at random
  task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
    logic [CFG_DATA_W-1:0] wd;
    wd = CFG_DATA_W'(w_raw);
    wd[CFG_DATA_W-1:FRAME_W_BITS] = (CFG_DATA_W - FRAME_W_BITS)'($urandom_range(0, 3));
    write_reg(REG_FRAME_WIDTH, wd);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
  endtask

  // one full frame plus its drain ticks, with stray words mixed in
  task automatic send_frame(input int unsigned ncolors);
    pix_t pal [4];
    int unsigned w, h, r, c;
    w = sb.active_width();
    h = sb.active_height();
    foreach (pal[i]) pal[i] = PIX_W'($urandom);
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if ($urandom_range(0, 99) < 4) send_word(KIND_DRAIN, PIX_W'($urandom));
        if (ncolors == 0) send_word(KIND_PIXEL, PIX_W'($urandom));
        else send_word(KIND_PIXEL, pal[$urandom_range(0, ncolors - 1)]);
      end
    end
    for (c = 0; c < w; c++) begin
      if ($urandom_range(0, 99) < 4) send_word(KIND_PIXEL, PIX_W'($urandom));
      send_word(KIND_DRAIN, PIX_W'($urandom));
    end
    if ($urandom_range(0, 99) < 10) send_word(KIND_DRAIN, PIX_W'($urandom));
  endtask

  // receiver: random ready pattern, one long hold-off when requested
  initial begin
    int unsigned run, gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap(steady_out);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    block_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.col = src_column;
      seen.row = src_row;
      seen.tl = top_left;
      seen.tr = top_right;
      seen.bl = bottom_left;
      seen.br = bottom_right;
      seen.last = last_of_run;
      seen.done = frame_done;
      sb.check_block(seen);
    end
  end

  initial begin
    int unsigned goal, w, h, i, roll;
    nbhd_t corner;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_PIXEL;
    pixel = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // drain tick with nothing pending is dropped
    send_word(KIND_DRAIN, 24'hFFFFFF);
    settle();

    // 3x3 frame of black, white and a mid color: edge rules, borders, row ends
    set_frame(3, 3);
    corner = {24'h000000, 24'hFFFFFF, 24'hFFFFFF,
              24'h000000, 24'h000000, 24'hFFFFFF,
              24'h123456, 24'h000000, 24'h000000};
    for (i = 0; i < 9; i++) send_word(KIND_PIXEL, corner[8 - i]);
    // pixel during the drain is dropped
    send_word(KIND_PIXEL, 24'hFFFFFF);
    for (i = 0; i < 3; i++) send_word(KIND_DRAIN, 24'h000000);
    send_word(KIND_DRAIN, 24'hFFFFFF);

    // smallest frames, including a zero register value that clamps
    foreach (extreme_w[k]) begin
      settle();
      set_frame(extreme_w[k], extreme_h[k]);
      send_frame(pick_colors());
    end

    // hold the receiver off while words keep coming, so the input stalls
    settle();
    set_frame(16, 8);
    steady_in = 1'b1;
    squeeze_req = 1'b1;
    send_frame(3);
    steady_in = 1'b0;

    // random frames, mostly small
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      settle();
      roll = $urandom_range(0, 99);
      if (roll < 70) w = $urandom_range(1, 8);
      else if (roll < 92) w = $urandom_range(9, 40);
      else w = $urandom_range(41, 120);
      h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      set_frame(w, h);
      steady_in = ($urandom_range(0, 9) == 0);
      steady_out = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(1, 2)) send_frame(pick_colors());
    end
    steady_in = 1'b0;
    steady_out = 1'b0;

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
